// ===== rtl/core/jfps_pkg.sv =====
package jfps_pkg;

  // field widths
  localparam int VAL_W     = 32;
  localparam int CHG_W     = 31;
  localparam int RW_W      = 11;
  localparam int WT_W      = 17;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  // datapath widths
  localparam int SUM_W  = VAL_W + 1;
  localparam int PROD_W = WT_W + 1 + SUM_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int BIAS_W = VAL_W + 17;
  localparam int FRAC_SHIFT = 16;
  localparam int Q_W    = ACC_W - FRAC_SHIFT;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_X    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Y    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_TERM = 8'd3;

  // reset values
  localparam logic [RW_W-1:0] ROW_WIDTH_RST = 11'd1024;
  localparam logic [WT_W-1:0] WEIGHT_RST    = 17'd16384;

  localparam int ROW_MIN = 3;

  // half lsb of the q1.16 weight product
  localparam logic signed [BIAS_W-1:0] ROUND_HALF = 49'sd32768;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic [CHG_W-1:0]        CHG_MAX = 31'h7FFF_FFFF;

  typedef logic signed [VAL_W-1:0] val_t;

  // per-item control that rides along the pipeline
  typedef struct packed {
    logic valid;
    logic has_below;
    logic use_stencil;
    logic top;
    logic done;
  } jfps_ctl_t;

  // stencil coefficients from the config registers
  typedef struct packed {
    logic [WT_W-1:0]          weight_x;
    logic [WT_W-1:0]          weight_y;
    logic signed [BIAS_W-1:0] bias;
  } jfps_coef_t;

endpackage

// ===== rtl/core/jfps_if.sv =====
interface jfps_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  point_value;
  logic                interior;
  logic                final_row;

  modport source (output valid, output point_value, output interior, output final_row,
                  input ready);
  modport sink   (input valid, input point_value, input interior, input final_row,
                  output ready);
endinterface

interface jfps_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  new_value;
  logic [30:0]         max_change;
  logic                sweep_done;

  modport source (output valid, output new_value, output max_change, output sweep_done,
                  input ready);
  modport sink   (input valid, input new_value, input max_change, input sweep_done,
                  output ready);
endinterface

interface jfps_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [31:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== rtl/core/jfps_line_store.sv =====
module jfps_line_store #(
  parameter int ROW_MAX = 1024,
  localparam int AW = $clog2(ROW_MAX)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [AW-1:0]         rd_addr,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [jfps_pkg::VAL_W:0]   wr_recent,
  input  logic [jfps_pkg::VAL_W-1:0] wr_older,
  output logic [jfps_pkg::VAL_W:0]   recent_q,
  output logic [jfps_pkg::VAL_W-1:0] older_q,
  output logic [AW-1:0]         pf_addr,
  output logic                  pf_ok
);
  import jfps_pkg::*;

  logic [VAL_W:0]   recent_mem [ROW_MAX];
  logic [VAL_W-1:0] older_mem  [ROW_MAX];

  logic            clr_r;
  logic [AW-1:0]   clr_addr_r;
  logic [AW-1:0]   pf_addr_r;
  logic            pf_ok_r;

  logic            we;
  logic [AW-1:0]   wa;
  logic [VAL_W:0]  wd_recent;
  logic [VAL_W-1:0] wd_older;

  // clearing pass owns the write port after reset
  always_comb begin
    we        = clr_r | wr_en;
    wa        = clr_r ? clr_addr_r : wr_addr;
    wd_recent = clr_r ? '0 : wr_recent;
    wd_older  = clr_r ? '0 : wr_older;
  end

  // both line stores, one write and one read port each
  always_ff @(posedge clk) begin
    if (we) begin
      recent_mem[wa] <= wd_recent;
      older_mem[wa]  <= wd_older;
    end
    recent_q <= recent_mem[rd_addr];
    older_q  <= older_mem[rd_addr];
  end

  // clear sweep and tracking of the address held in the read registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      pf_ok_r    <= 1'b0;
    end else begin
      if (clr_r) begin
        if (clr_addr_r == AW'(ROW_MAX - 1)) begin
          clr_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      pf_ok_r <= ~clr_r;
    end
  end

  always_ff @(posedge clk) begin
    pf_addr_r <= rd_addr;
  end

  assign pf_addr = pf_addr_r;
  assign pf_ok   = pf_ok_r;

endmodule

// ===== rtl/core/jfps_stencil_pipe.sv =====
module jfps_stencil_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  jfps_pkg::jfps_coef_t       coef,
  input  jfps_pkg::jfps_ctl_t        ctl_i,
  input  jfps_pkg::val_t             old_i,
  input  jfps_pkg::val_t             above_i,
  input  jfps_pkg::val_t             left_i,
  input  jfps_pkg::val_t             right_i,
  input  jfps_pkg::val_t             below_i,
  output jfps_pkg::jfps_ctl_t        ctl_o,
  output jfps_pkg::val_t             above_o,
  output jfps_pkg::val_t             nv_o,
  output logic [jfps_pkg::CHG_W-1:0] chg_o
);
  import jfps_pkg::*;

  // control per stage
  jfps_ctl_t c2_r, c3_r, c4_r, c5_r, c6_r, c7_r;

  // data per stage
  logic signed [SUM_W-1:0]  sx2_r, sy2_r;
  logic signed [PROD_W-1:0] px3_r, py3_r;
  logic signed [ACC_W-1:0]  acc4_r;
  val_t                     old2_r, old3_r, old4_r, old5_r;
  val_t                     ab2_r, ab3_r, ab4_r, ab5_r, ab6_r, ab7_r;
  val_t                     nv5_r, nv6_r, nv7_r;
  logic signed [SUM_W-1:0]  d6_r;
  logic [CHG_W-1:0]         chg7_r;

  logic signed [SUM_W-1:0]  sx_nxt, sy_nxt;
  logic signed [PROD_W-1:0] px_nxt, py_nxt;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [Q_W-1:0]    q;
  val_t                     sat;
  val_t                     nv_nxt;
  logic signed [SUM_W-1:0]  d_nxt;
  logic signed [SUM_W:0]    dd;
  logic signed [SUM_W:0]    mag;
  logic [CHG_W-1:0]         chg_nxt;

  // neighbor pair sums
  always_comb begin
    sx_nxt = {left_i[VAL_W-1], left_i} + {right_i[VAL_W-1], right_i};
    sy_nxt = {below_i[VAL_W-1], below_i} + {above_i[VAL_W-1], above_i};
  end

  // weight products
  always_comb begin
    px_nxt = $signed({1'b0, coef.weight_x}) * sx2_r;
    py_nxt = $signed({1'b0, coef.weight_y}) * sy2_r;
  end

  // sum with rounding and the scaled source term folded into one bias
  always_comb begin
    acc_nxt = {px3_r[PROD_W-1], px3_r} + {py3_r[PROD_W-1], py3_r}
            + {{(ACC_W - BIAS_W){coef.bias[BIAS_W-1]}}, coef.bias};
  end

  // floor to q8.24 and saturate
  always_comb begin
    q = acc4_r[ACC_W-1:FRAC_SHIFT];
    if ((&q[Q_W-1:VAL_W-1]) || !(|q[Q_W-1:VAL_W-1])) begin
      sat = q[VAL_W-1:0];
    end else if (q[Q_W-1]) begin
      sat = VAL_MIN;
    end else begin
      sat = VAL_MAX;
    end
    nv_nxt = c4_r.use_stencil ? sat : old4_r;
  end

  // signed change
  always_comb begin
    d_nxt = {nv5_r[VAL_W-1], nv5_r} - {old5_r[VAL_W-1], old5_r};
  end

  // magnitude, saturated to 31 bits
  always_comb begin
    dd  = {d6_r[SUM_W-1], d6_r};
    mag = dd[SUM_W] ? -dd : dd;
    if (|mag[SUM_W:CHG_W]) begin
      chg_nxt = CHG_MAX;
    end else begin
      chg_nxt = mag[CHG_W-1:0];
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
      c7_r <= '0;
    end else if (adv) begin
      c2_r <= ctl_i;
      c3_r <= c2_r;
      c4_r <= c3_r;
      c5_r <= c4_r;
      c6_r <= c5_r;
      c7_r <= c6_r;
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (adv) begin
      sx2_r  <= sx_nxt;
      sy2_r  <= sy_nxt;
      old2_r <= old_i;
      ab2_r  <= above_i;
      px3_r  <= px_nxt;
      py3_r  <= py_nxt;
      old3_r <= old2_r;
      ab3_r  <= ab2_r;
      acc4_r <= acc_nxt;
      old4_r <= old3_r;
      ab4_r  <= ab3_r;
      nv5_r  <= nv_nxt;
      old5_r <= old4_r;
      ab5_r  <= ab4_r;
      d6_r   <= d_nxt;
      nv6_r  <= nv5_r;
      ab6_r  <= ab5_r;
      chg7_r <= chg_nxt;
      nv7_r  <= nv6_r;
      ab7_r  <= ab6_r;
    end
  end

  assign ctl_o   = c7_r;
  assign above_o = ab7_r;
  assign nv_o    = nv7_r;
  assign chg_o   = chg7_r;

endmodule

// ===== rtl/core/jfps_out_stage.sv =====
module jfps_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  jfps_pkg::jfps_ctl_t        ctl_i,
  input  jfps_pkg::val_t             above_i,
  input  jfps_pkg::val_t             nv_i,
  input  logic [jfps_pkg::CHG_W-1:0] chg_i,
  output logic                       adv,
  jfps_out_if.source                 out_ch
);
  import jfps_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  logic             sec_pend_r, sec_pend_nxt;
  val_t             out_val_r, out_val_nxt;
  logic [CHG_W-1:0] out_max_r, out_max_nxt;
  logic             out_done_r, out_done_nxt;
  val_t             sec_val_r, sec_val_nxt;
  logic             sec_done_r, sec_done_nxt;
  logic [CHG_W-1:0] largest_r, largest_nxt;

  logic             load;
  logic [CHG_W-1:0] lmax;

  // pipeline moves when the output word and its follower are gone
  assign adv  = ~out_valid_r | (out_ch.ready & ~sec_pend_r);
  assign load = adv & ctl_i.valid & (ctl_i.has_below | ctl_i.top);

  // running maximum and result sequencing
  always_comb begin
    out_valid_nxt = out_valid_r;
    sec_pend_nxt  = sec_pend_r;
    out_val_nxt   = out_val_r;
    out_max_nxt   = out_max_r;
    out_done_nxt  = out_done_r;
    sec_val_nxt   = sec_val_r;
    sec_done_nxt  = sec_done_r;
    largest_nxt   = largest_r;

    lmax = (ctl_i.has_below && (chg_i > largest_r)) ? chg_i : largest_r;

    if (out_valid_r && out_ch.ready) begin
      if (sec_pend_r) begin
        out_val_nxt  = sec_val_r;
        out_done_nxt = sec_done_r;
        sec_pend_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end

    if (load) begin
      out_valid_nxt = 1'b1;
      out_max_nxt   = lmax;
      out_val_nxt   = ctl_i.has_below ? nv_i : above_i;
      out_done_nxt  = ctl_i.has_below ? 1'b0 : ctl_i.done;
      sec_pend_nxt  = ctl_i.has_below & ctl_i.top;
      sec_val_nxt   = above_i;
      sec_done_nxt  = ctl_i.done;
      largest_nxt   = ctl_i.done ? '0 : lmax;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_pend_r  <= 1'b0;
      largest_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_pend_r  <= sec_pend_nxt;
      largest_r   <= largest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_val_r  <= out_val_nxt;
    out_max_r  <= out_max_nxt;
    out_done_r <= out_done_nxt;
    sec_val_r  <= sec_val_nxt;
    sec_done_r <= sec_done_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.new_value  = out_val_r;
  assign out_ch.max_change = out_max_r;
  assign out_ch.sweep_done = out_done_r;

endmodule

// ===== rtl/core/jacobi_five_point_stencil.sv =====
// Path: a point's first result passes the entry stage, the stencil pipe and the output register.
// Throughput: one point per cycle while the output is ready; the single output port moves one
// word per cycle, so a top-row point with a point below it holds the input while the second
// word of that point waits. Reset: synchronous, active low; afterwards both line stores are
// cleared, one entry per cycle, with in_ch.ready low; configuration writes are taken throughout.
module jacobi_five_point_stencil #(
  parameter int ROW_MAX = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  jfps_in_if.sink    in_ch,
  jfps_out_if.source out_ch,
  jfps_cfg_if.sink   cfg_ch
);
  import jfps_pkg::*;

  localparam int AW = $clog2(ROW_MAX);

  // config registers
  logic [RW_W-1:0]          row_width_r;
  logic [WT_W-1:0]          weight_x_r;
  logic [WT_W-1:0]          weight_y_r;
  logic signed [BIAS_W-1:0] bias_r;
  logic signed [BIAS_W-1:0] src_scaled;
  logic                     cfg_wr;

  // scan state
  logic [AW-1:0] column_r;
  logic [1:0]    row_count_r;
  val_t          prev_old_r;

  // column arithmetic
  logic [31:0]   w_raw, w_cl, col_ext, c_ext;
  logic          last;
  logic [AW-1:0] c_eff, next_col, rd_addr;

  // line store ports
  logic [VAL_W:0]   recent_q;
  logic [VAL_W-1:0] older_q;
  logic [AW-1:0]    pf_addr;
  logic             pf_ok;

  logic adv;
  logic accept;

  // entry stage
  jfps_ctl_t s1_ctl_r, s1_ctl_nxt;
  val_t      s1_old_r, s1_above_r, s1_left_r, s1_below_r;

  jfps_coef_t coef;
  jfps_ctl_t  p_ctl;
  val_t       p_above, p_nv;
  logic [CHG_W-1:0] p_chg;

  // config writes
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid & cfg_ch.ready;
  assign src_scaled   = {cfg_ch.wr_data[CFG_DAT_W-1], cfg_ch.wr_data, 16'h0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      weight_x_r  <= WEIGHT_RST;
      weight_y_r  <= WEIGHT_RST;
      bias_r      <= ROUND_HALF;
    end else if (cfg_wr) begin
      case (cfg_ch.reg_index)
        REG_ROW_WIDTH:   row_width_r <= cfg_ch.wr_data[RW_W-1:0];
        REG_WEIGHT_X:    weight_x_r  <= cfg_ch.wr_data[WT_W-1:0];
        REG_WEIGHT_Y:    weight_y_r  <= cfg_ch.wr_data[WT_W-1:0];
        REG_SOURCE_TERM: bias_r      <= ROUND_HALF - src_scaled;
        default: ;
      endcase
    end
  end

  assign coef = '{weight_x: weight_x_r, weight_y: weight_y_r, bias: bias_r};

  // effective column, clamped row width
  always_comb begin
    w_raw = {{(32 - RW_W){1'b0}}, row_width_r};
    if (w_raw < 32'(ROW_MIN)) begin
      w_cl = 32'(ROW_MIN);
    end else if (w_raw > 32'(ROW_MAX)) begin
      w_cl = 32'(ROW_MAX);
    end else begin
      w_cl = w_raw;
    end
    col_ext  = {{(32 - AW){1'b0}}, column_r};
    c_ext    = (col_ext >= w_cl) ? (w_cl - 32'd1) : col_ext;
    last     = (c_ext + 32'd1) >= w_cl;
    c_eff    = c_ext[AW-1:0];
    next_col = last ? '0 : c_eff + 1'b1;
  end

  // take a point only when the read registers hold its column
  assign in_ch.ready = adv & pf_ok & (pf_addr == c_eff);
  assign accept      = in_ch.valid & in_ch.ready;
  assign rd_addr     = accept ? next_col : c_eff;

  jfps_line_store #(.ROW_MAX(ROW_MAX)) u_line_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (rd_addr),
    .wr_en     (accept),
    .wr_addr   (c_eff),
    .wr_recent ({in_ch.interior, in_ch.point_value}),
    .wr_older  (recent_q[VAL_W-1:0]),
    .recent_q  (recent_q),
    .older_q   (older_q),
    .pf_addr   (pf_addr),
    .pf_ok     (pf_ok)
  );

  // column and row progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      row_count_r <= '0;
    end else if (accept) begin
      if (in_ch.final_row && last) begin
        column_r    <= '0;
        row_count_r <= '0;
      end else if (last) begin
        column_r <= '0;
        if (row_count_r != 2'd2) begin
          row_count_r <= row_count_r + 2'd1;
        end
      end else begin
        column_r <= next_col;
      end
    end
  end

  // entry stage control
  always_comb begin
    s1_ctl_nxt.valid       = accept;
    s1_ctl_nxt.has_below   = row_count_r != 2'd0;
    s1_ctl_nxt.use_stencil = recent_q[VAL_W] & (row_count_r == 2'd2)
                           & (c_eff != '0) & ~last;
    s1_ctl_nxt.top         = in_ch.final_row;
    s1_ctl_nxt.done        = in_ch.final_row & last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  // neighbor capture; left is the value that went to the older row one point back
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_old_r   <= recent_q[VAL_W-1:0];
      s1_above_r <= in_ch.point_value;
      s1_left_r  <= prev_old_r;
      s1_below_r <= older_q;
      prev_old_r <= recent_q[VAL_W-1:0];
    end
  end

  // right neighbor arrives from the read port in the cycle after entry
  jfps_stencil_pipe u_stencil_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .coef    (coef),
    .ctl_i   (s1_ctl_r),
    .old_i   (s1_old_r),
    .above_i (s1_above_r),
    .left_i  (s1_left_r),
    .right_i (recent_q[VAL_W-1:0]),
    .below_i (s1_below_r),
    .ctl_o   (p_ctl),
    .above_o (p_above),
    .nv_o    (p_nv),
    .chg_o   (p_chg)
  );

  jfps_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (p_ctl),
    .above_i (p_above),
    .nv_i    (p_nv),
    .chg_i   (p_chg),
    .adv     (adv),
    .out_ch  (out_ch)
  );

endmodule

// ===== bench/tb_jacobi_five_point_stencil.sv =====
`timescale 1ns / 100ps

module tb_jacobi_five_point_stencil;
  import jfps_pkg::*;

  localparam int ROW_MAX      = 1024;
  localparam int DRAIN_CYCLES = 24;
  localparam int LIMIT_NS     = 1_600_000;
  localparam int RAND_PHASES  = 4;
  localparam int PHASE_POINTS = 30;

  // index past the four registers, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd200;

  typedef struct {
    logic signed [31:0] value;
    logic               interior;
    logic               top;
    logic               drain;
  } grid_point_t;

  typedef struct {
    logic signed [31:0] new_value;
    logic [30:0]        max_change;
    logic               sweep_done;
  } released_t;

  logic clk;
  logic rst_n;

  jfps_in_if  in_ch ();
  jfps_out_if out_ch ();
  jfps_cfg_if cfg_ch ();

  jacobi_five_point_stencil #(
    .ROW_MAX(ROW_MAX)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // grid model: registers and line stores
  logic [10:0]        cur_row_width;
  logic [16:0]        cur_weight_x;
  logic [16:0]        cur_weight_y;
  logic signed [31:0] cur_source;
  logic signed [31:0] row_val  [ROW_MAX];
  logic               row_flag [ROW_MAX];
  logic signed [31:0] prev_row [ROW_MAX];
  int unsigned        col_pos;
  int unsigned        rows_done;
  logic [30:0]        peak_change;

  grid_point_t point_queue [$];
  released_t   released_q  [$];

  int mismatch_count;
  int src_idle_pct;
  int snk_stall_pct;
  int unsigned gen_width;
  int unsigned gen_col;
  int phase_items;

  function automatic int unsigned grid_width();
    int unsigned w;
    w = cur_row_width;
    if (w < ROW_MIN) w = ROW_MIN;
    if (w > ROW_MAX) w = ROW_MAX;
    return w;
  endfunction

  function automatic logic signed [31:0] clamp_value(longint v);
    if (v > longint'(VAL_MAX)) return VAL_MAX;
    if (v < longint'(VAL_MIN)) return VAL_MIN;
    return v[31:0];
  endfunction

  // weighted neighbor sum, rounded to q8.24, minus the source term
  function automatic logic signed [31:0] relax_value(logic signed [31:0] l, logic signed [31:0] r,
                                                    logic signed [31:0] b, logic signed [31:0] a);
    longint acc;
    acc = longint'(cur_weight_x) * (longint'(l) + longint'(r))
        + longint'(cur_weight_y) * (longint'(b) + longint'(a))
        + longint'(32768);
    return clamp_value((acc >>> 16) - longint'(cur_source));
  endfunction

  // queue one released point and track the largest change
  task automatic push_released(logic signed [31:0] nv, logic signed [31:0] old, logic done);
    longint    d;
    released_t r;
    d = longint'(nv) - longint'(old);
    if (d < 0) d = -d;
    if (d > longint'(CHG_MAX)) d = longint'(CHG_MAX);
    if (d > longint'(peak_change)) peak_change = d[30:0];
    r.new_value  = nv;
    r.max_change = peak_change;
    r.sweep_done = done;
    released_q.push_back(r);
  endtask

  // one accepted point: release the point below and, on the top row, itself
  task automatic release_points(logic signed [31:0] value, logic interior, logic top);
    int unsigned        w;
    int unsigned        c;
    logic               last;
    logic signed [31:0] old;
    logic signed [31:0] nv;
    w = grid_width();
    c = col_pos;
    if (c >= w) c = w - 1;
    last = (c + 1 >= w);
    if (rows_done >= 1) begin
      old = row_val[c];
      nv  = old;
      if (row_flag[c] && rows_done >= 2 && c > 0 && !last)
        nv = relax_value(prev_row[c-1], row_val[c+1], prev_row[c], value);
      push_released(nv, old, 1'b0);
    end
    prev_row[c] = row_val[c];
    row_val[c]  = value;
    row_flag[c] = interior;
    if (top) push_released(value, value, last);
    if (top && last) begin
      col_pos     = 0;
      rows_done   = 0;
      peak_change = '0;
    end else if (last) begin
      col_pos = 0;
      if (rows_done < 2) rows_done++;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
    mismatch_count++;
  endtask

  // input driver
  always @(posedge clk) begin : point_driver
    grid_point_t nxt;
    logic        present;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        release_points(in_ch.point_value, in_ch.interior, in_ch.final_row);
      if (!in_ch.valid || in_ch.ready) begin
        present = 1'b0;
        // a drain marker holds the sender until nothing is awaited
        if (point_queue.size() > 0 && point_queue[0].drain && released_q.size() == 0)
          void'(point_queue.pop_front());
        if (point_queue.size() > 0 && !point_queue[0].drain &&
            $urandom_range(99) >= src_idle_pct) begin
          nxt = point_queue.pop_front();
          in_ch.point_value <= nxt.value;
          in_ch.interior    <= nxt.interior;
          in_ch.final_row   <= nxt.top;
          present = 1'b1;
        end
        in_ch.valid <= present;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    released_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (released_q.size() == 0) begin
          report_mismatch("unexpected word", out_ch.new_value, 0);
        end else begin
          want = released_q.pop_front();
          if (out_ch.new_value !== want.new_value)
            report_mismatch("new_value", out_ch.new_value, want.new_value);
          if (out_ch.max_change !== want.max_change)
            report_mismatch("max_change", out_ch.max_change, want.max_change);
          if (out_ch.sweep_done !== want.sweep_done)
            report_mismatch("sweep_done", out_ch.sweep_done, want.sweep_done);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  function automatic logic signed [31:0] rand_val();
    int t;
    case ($urandom_range(7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3: begin
        t = $urandom_range(0, 134217728);
        return t - 67108864;
      end
      default: return $urandom;
    endcase
  endfunction

  // width with junk in the unused upper bits
  function automatic logic [31:0] width_word(int unsigned w);
    return ($urandom & 32'hFFFF_F800) | (w & 32'h7FF);
  endfunction

  function automatic logic [31:0] pick_width();
    case ($urandom_range(9))
      0:       return width_word($urandom_range(0, 2));
      1:       return width_word($urandom_range(13, 40));
      default: return width_word($urandom_range(3, 12));
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'd65536;
      2:       return 32'h0001_FFFF;
      3:       return $urandom;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic logic [31:0] pick_source();
    case ($urandom_range(7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return 32'd0;
      3:       return rand_val();
      default: return $urandom;
    endcase
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    case (idx)
      REG_ROW_WIDTH:   cur_row_width = data[10:0];
      REG_WEIGHT_X:    cur_weight_x  = data[16:0];
      REG_WEIGHT_Y:    cur_weight_y  = data[16:0];
      REG_SOURCE_TERM: cur_source    = data;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  // wait until every point is taken and every result is back;
  // checked mid-cycle so the driver's updates of this edge are settled
  task automatic wait_idle();
    do @(negedge clk);
    while (point_queue.size() != 0 || in_ch.valid || released_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic begin_phase(logic [31:0] rw, logic [31:0] wx, logic [31:0] wy,
                             logic [31:0] src, int src_idle, int snk_stall);
    wait_idle();
    cfg_write(REG_ROW_WIDTH, rw);
    cfg_write(REG_WEIGHT_X, wx);
    cfg_write(REG_WEIGHT_Y, wy);
    cfg_write(REG_SOURCE_TERM, src);
    src_idle_pct  = src_idle;
    snk_stall_pct = snk_stall;
    gen_width     = grid_width();
    gen_col       = (col_pos >= gen_width) ? gen_width - 1 : col_pos;
    phase_items   = 0;
  endtask

  task automatic queue_point(logic signed [31:0] value, logic interior, logic top);
    grid_point_t p;
    p.value    = value;
    p.interior = interior;
    p.top      = top;
    p.drain    = 1'b0;
    point_queue.push_back(p);
    phase_items++;
    gen_col = (gen_col + 1 >= gen_width) ? 0 : gen_col + 1;
  endtask

  task automatic queue_drain();
    grid_point_t p;
    p.value    = '0;
    p.interior = 1'b0;
    p.top      = 1'b0;
    p.drain    = 1'b1;
    point_queue.push_back(p);
  endtask

  // full sweep, after closing any row in progress
  task automatic queue_sweep();
    int rows;
    int r;
    int x;
    rows = $urandom_range(2, 5);
    while (gen_col != 0) queue_point(rand_val(), $urandom_range(1), 1'b0);
    for (r = 0; r < rows; r++)
      for (x = 0; x < gen_width; x++)
        queue_point(rand_val(), $urandom_range(99) < 88, r == rows - 1);
  endtask

  // broken stretch with stray top-row flags
  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 2 * gen_width);
    repeat (n) queue_point(rand_val(), $urandom_range(1), $urandom_range(99) < 30);
  endtask

  // stimulus
  initial begin : stimulus
    int ph;
    int k;
    logic drained;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.point_value = '0;
    in_ch.interior    = 1'b0;
    in_ch.final_row   = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.reg_index  = '0;
    cfg_ch.wr_data    = '0;
    src_idle_pct      = 0;
    snk_stall_pct     = 0;
    mismatch_count    = 0;
    cur_row_width     = ROW_WIDTH_RST;
    cur_weight_x      = WEIGHT_RST;
    cur_weight_y      = WEIGHT_RST;
    cur_source        = '0;
    col_pos           = 0;
    rows_done         = 0;
    peak_change       = '0;
    for (k = 0; k < ROW_MAX; k++) begin
      row_val[k]  = '0;
      row_flag[k] = 1'b0;
      prev_row[k] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // width below minimum, unit weights, most negative source: saturation
    begin_phase(width_word(0), 32'd65536, 32'd65536, VAL_MIN, 0, 0);
    queue_point(VAL_MAX, 1'b1, 1'b0);
    queue_point(VAL_MIN, 1'b1, 1'b0);
    queue_point(VAL_MAX, 1'b1, 1'b0);
    queue_point(VAL_MAX, 1'b1, 1'b0);
    queue_point(VAL_MAX, 1'b1, 1'b0);
    queue_point(VAL_MIN, 1'b1, 1'b0);
    queue_point(VAL_MIN, 1'b1, 1'b0);
    queue_point(VAL_MAX, 1'b1, 1'b0);
    queue_point(VAL_MAX, 1'b0, 1'b0);
    queue_point(32'sd1, 1'b1, 1'b1);
    queue_point(-32'sd1, 1'b1, 1'b1);
    queue_point(32'sd0, 1'b1, 1'b1);

    // no horizontal weight, largest vertical weight, most positive source
    begin_phase(width_word(3), 32'd0, 32'h0001_FFFF, VAL_MAX, 0, 0);
    cfg_write(REG_UNUSED, $urandom);
    queue_point(VAL_MIN, 1'b1, 1'b0);
    queue_point(VAL_MIN, 1'b1, 1'b0);
    queue_point(32'sd0, 1'b1, 1'b0);
    queue_point(VAL_MAX, 1'b1, 1'b0);
    queue_point(VAL_MIN, 1'b1, 1'b0);
    queue_point(VAL_MAX, 1'b1, 1'b0);
    queue_point(VAL_MIN, 1'b0, 1'b1);
    queue_point(VAL_MIN, 1'b1, 1'b1);
    queue_point(VAL_MAX, 1'b1, 1'b1);

    // width above maximum: one full row, then part of a second
    begin_phase(width_word(2047), WEIGHT_RST, WEIGHT_RST, 32'd0, 0, 0);
    for (k = 0; k < ROW_MAX + 8; k++)
      queue_point(rand_val(), $urandom_range(99) < 90, 1'b0);

    // random phases; the first one shrinks the width behind the column
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: begin_phase(ph == 0 ? width_word(5) : pick_width(), pick_weight(), pick_weight(),
                       pick_source(), 0, 0);
        1: begin_phase(pick_width(), pick_weight(), pick_weight(), pick_source(), 58, 0);
        2: begin_phase(pick_width(), pick_weight(), pick_weight(), pick_source(), 0, 58);
        default: begin_phase(pick_width(), pick_weight(), pick_weight(), pick_source(), 23, 23);
      endcase
      if (ph == 3) cfg_write(REG_UNUSED, $urandom);
      drained = 1'b0;
      while (phase_items < PHASE_POINTS) begin
        if (!drained && phase_items >= PHASE_POINTS / 2) begin
          queue_drain();
          drained = 1'b1;
        end
        if ($urandom_range(99) < 85) queue_sweep();
        else queue_noise();
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
